>>> sv/locd_pkg.sv
// Shared types and constants for the LRU object cache directory.
// Depends on nothing; used by the directory top level.
package locd_pkg;

	localparam int KEY_W            = 32;
	localparam int LEN_W            = 17;
	localparam int STAMP_W          = 32;
	localparam int SLOT_W           = 4;
	localparam int DEF_ENTRIES      = 16;
	localparam int MAX_OBJECT_BYTES = 102400;

	// Request kind codes.
	typedef enum logic {
		KIND_LOOKUP = 1'b0,
		KIND_INSERT = 1'b1
	} kind_t;

	// One request beat.
	typedef struct packed {
		kind_t              kind;
		logic [KEY_W-1:0]   key;
		logic [LEN_W-1:0]   object_length;
	} req_t;

	// One response beat.
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic [LEN_W-1:0]   stored_length;
		logic               evicted;
	} rsp_t;

	// One directory slot as held in the entry memory.
	typedef struct packed {
		logic [KEY_W-1:0]   tag;
		logic [LEN_W-1:0]   length;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

endpackage

>>> sv/lru_object_cache_directory.sv
// Fully associative object directory with least-recently-used replacement.
// Depends on locd_pkg and locd_ram.

// The directory takes one request at a time. Slots live in a single entry
// memory with a registered read, and each lookup or eviction walks that memory
// one slot per cycle. An insert into a free slot skips the scan and goes
// straight to the write state; a lookup in an empty directory skips it too.
// A lookup stops at the first hit, a lookup miss walks the filled slots, and
// an insert that evicts walks all ENTRIES slots. The slot scan through the
// memory read port sets the time that a request takes. A new request is taken
// once the previous result sits in the response register, even if it is
// still stalled.
// Empty slots never match. Duplicate keys are not checked on insert; a lookup
// returns the lowest matching slot. The victim is the smallest stamp by
// unsigned compare, lowest index on a tie; stamps wrap modulo 2^32.
module lru_object_cache_directory #(
	parameter int ENTRIES = locd_pkg::DEF_ENTRIES
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  locd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output locd_pkg::rsp_t rsp
);

	import locd_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int ENT_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_WRITE = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	state_t             state_q;
	kind_t              kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [LEN_W-1:0]   len_q;
	logic [IDX_W-1:0]   slot_q;
	logic               hit_q;
	logic               evict_q;
	logic [CNT_W-1:0]   issue_q;
	logic               rd_v_s1;
	logic [IDX_W-1:0]   addr_s1;
	logic [IDX_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic [CNT_W-1:0]   fill_q;
	logic [STAMP_W-1:0] use_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               ram_re;
	logic               ram_we;
	logic [ENT_W-1:0]   ram_rdata;
	entry_t             rd_entry;
	entry_t             wr_entry;
	logic [CNT_W-1:0]   limit;
	logic               last_s1;
	logic               take_s1;
	logic [IDX_W-1:0]   new_best;
	logic               full;

	// Scan bounds: lookups walk the filled slots, evictions walk them all.
	assign full     = (fill_q == CNT_W'(ENTRIES));
	assign limit    = (kind_q == KIND_INSERT) ? CNT_W'(ENTRIES) : fill_q;
	assign last_s1  = (CNT_W'(addr_s1) == (limit - CNT_W'(1)));
	assign rd_entry = ram_rdata;

	// Running minimum of the stamps, earliest index kept on a tie.
	assign take_s1  = (addr_s1 == '0) || (rd_entry.stamp < best_stamp_q);
	assign new_best = take_s1 ? addr_s1 : best_idx_q;

	// Memory control: reads only while scanning, writes only in the write state.
	assign ram_re  = (state_q == ST_SCAN) && (issue_q < limit);
	assign ram_we  = (state_q == ST_WRITE);
	assign wr_entry = '{tag: key_q, length: len_q, stamp: use_q};

	locd_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ENTRIES)
	) u_entry_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (issue_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Request payload and scan working registers.
	always_ff @(posedge clk) begin
		addr_s1 <= issue_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					kind_q  <= req.kind;
					key_q   <= req.key;
					len_q   <= req.object_length;
					hit_q   <= 1'b0;
					evict_q <= (req.kind == KIND_INSERT) && full;
					slot_q  <= (req.kind == KIND_INSERT && !full) ?
					           fill_q[IDX_W-1:0] : '0;
				end
			end
			ST_SCAN: begin
				if (rd_v_s1) begin
					if (kind_q == KIND_LOOKUP) begin
						if (rd_entry.tag == key_q) begin
							hit_q  <= 1'b1;
							slot_q <= addr_s1;
							len_q  <= rd_entry.length;
						end
					end else begin
						best_idx_q   <= new_best;
						best_stamp_q <= take_s1 ? rd_entry.stamp : best_stamp_q;
						if (last_s1) begin
							slot_q <= new_best;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, counters and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= '0;
			rd_v_s1     <= 1'b0;
			fill_q      <= '0;
			use_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= ram_re;
			if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						issue_q <= '0;
						if (req.kind == KIND_INSERT && !full) begin
							state_q <= ST_WRITE;
						end else if (req.kind == KIND_LOOKUP && fill_q == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (ram_re) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (rd_v_s1) begin
						if (kind_q == KIND_LOOKUP) begin
							if (rd_entry.tag == key_q) begin
								state_q <= ST_WRITE;
							end else if (last_s1) begin
								state_q <= ST_DONE;
							end
						end else if (last_s1) begin
							state_q <= ST_WRITE;
						end
					end
				end
				ST_WRITE: begin
					use_q <= use_q + STAMP_W'(1);
					if (kind_q == KIND_INSERT && !evict_q) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response payload, loaded as the sequencer leaves the done state.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q.hit           <= hit_q;
			rsp_q.slot          <= SLOT_W'(slot_q);
			rsp_q.stored_length <= hit_q ? len_q : '0;
			rsp_q.evicted       <= evict_q;
		end
	end

	// The fill count never passes the slot count.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ENTRIES))
		else $error("fill count above slot count");

	// The memory is never read and written in the same cycle.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !ram_re)
		else $error("entry memory read during write-back");

	// Every write-back consumes exactly one stamp.
	a_stamp_step: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (use_q == $past(use_q) + STAMP_W'(1)))
		else $error("use counter did not advance on write-back");

	// A hit is never reported together with an eviction.
	a_hit_excl_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.hit) |-> !rsp_q.evicted)
		else $error("hit and eviction in one response");

endmodule

>>> sv/locd_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
module locd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data in the cycle after the address.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> bench/testbench.sv
// Self-checking bench for the LRU object cache directory: directed and random
// lookups and inserts, checked beat by beat against a tracking model of the slots.
// Depends on locd_pkg and lru_object_cache_directory.
`timescale 1ns / 1ps

module testbench;
	import locd_pkg::*;

	localparam int N_SLOTS   = DEF_ENTRIES;
	localparam int POOL_SIZE = 24;
	localparam int DRAIN_CYC = 40;

	// Tracks slot contents, stamps and the use counter; predicts each response.
	class slot_tracker;
		logic [KEY_W-1:0]   tags   [N_SLOTS];
		logic [LEN_W-1:0]   lens   [N_SLOTS];
		logic [STAMP_W-1:0] stamps [N_SLOTS];
		int unsigned        filled;
		logic [STAMP_W-1:0] use_count;
		rsp_t               awaited_rsp [$];
		int unsigned        errors;

		function new();
			filled    = 0;
			use_count = '0;
			errors    = 0;
		endfunction

		// An accepted request beat: update the slots and queue the response due.
		function void note_request(req_t r);
			rsp_t e;
			int   idx;
			int   victim;
			e = '0;
			if (r.kind == KIND_LOOKUP) begin
				// First filled slot holding the key wins; empty slots never match.
				for (idx = 0; idx < filled && !e.hit; idx++) begin
					if (tags[idx] == r.key) begin
						e.hit           = 1'b1;
						e.slot          = SLOT_W'(idx);
						e.stored_length = lens[idx];
						stamps[idx]     = use_count;
						use_count       = use_count + 1'b1;
					end
				end
			end else begin
				if (filled < N_SLOTS) begin
					victim = filled;
					filled++;
				end else begin
					// Smallest stamp by unsigned compare, lowest index on a tie.
					victim = 0;
					for (idx = 1; idx < N_SLOTS; idx++) begin
						if (stamps[idx] < stamps[victim])
							victim = idx;
					end
					e.evicted = 1'b1;
				end
				tags[victim]   = r.key;
				lens[victim]   = r.object_length;
				stamps[victim] = use_count;
				use_count      = use_count + 1'b1;
				e.slot         = SLOT_W'(victim);
			end
			awaited_rsp.push_back(e);
		endfunction

		// An accepted response beat: compare it with the oldest prediction.
		function void check_response(rsp_t got);
			rsp_t e;
			if (awaited_rsp.size() == 0) begin
				$display("%0t: unexpected response beat %h", $time, got);
				errors++;
			end else begin
				e = awaited_rsp.pop_front();
				if (got.hit !== e.hit) begin
					$display("%0t: hit mismatch, expected %0d, got %0d",
						$time, e.hit, got.hit);
					errors++;
				end
				if (got.slot !== e.slot) begin
					$display("%0t: slot mismatch, expected %0d, got %0d",
						$time, e.slot, got.slot);
					errors++;
				end
				if (got.stored_length !== e.stored_length) begin
					$display("%0t: stored_length mismatch, expected %0d, got %0d",
						$time, e.stored_length, got.stored_length);
					errors++;
				end
				if (got.evicted !== e.evicted) begin
					$display("%0t: evicted mismatch, expected %0d, got %0d",
						$time, e.evicted, got.evicted);
					errors++;
				end
			end
		endfunction

		function int unsigned pending();
			return awaited_rsp.size();
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int unsigned        send_idle_pct  = 0;
	int unsigned        recv_stall_pct = 0;
	logic               hold_armed     = 1'b0;
	logic [KEY_W-1:0]   key_pool [POOL_SIZE];
	slot_tracker        book;

	lru_object_cache_directory #(
		.ENTRIES(N_SLOTS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic req_t compose_request(kind_t k, logic [KEY_W-1:0] key,
			logic [LEN_W-1:0] len);
		req_t r;
		r.kind          = k;
		r.key           = key;
		r.object_length = len;
		return r;
	endfunction

	// Mostly keys from a small pool so lookups hit and inserts evict often.
	function automatic req_t random_request();
		req_t r;
		r.kind = ($urandom_range(99) < 35) ? KIND_INSERT : KIND_LOOKUP;
		if ($urandom_range(9) == 0)
			r.key = $urandom;
		else
			r.key = key_pool[$urandom_range(POOL_SIZE - 1)];
		if ($urandom_range(9) == 0)
			r.object_length = LEN_W'($urandom);
		else
			r.object_length = LEN_W'($urandom_range(MAX_OBJECT_BYTES - 1));
		return r;
	endfunction

	// Offer one request beat, with random idle cycles first, and wait for it to be taken.
	task automatic offer_request(req_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
		book.note_request(r);
	endtask

	task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned count);
		int unsigned n;
		send_idle_pct  = idle_pct;
		recv_stall_pct <= stall_pct;
		for (n = 0; n < count; n++)
			offer_request(random_request());
	endtask

	// Response side: check accepted beats and choose the stall for the next cycle.
	initial begin
		int unsigned hold_left;
		bit          hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall)
				book.check_response(rsp);
			if (hold_armed && !hold_used) begin
				hold_left = 300;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Main sequence: reset, directed beats, then random phases with varied idling and stalling.
	initial begin
		int i;
		book = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty directory: nothing matches, not even a key of zero.
		offer_request(compose_request(KIND_LOOKUP, 32'h0000_0000, '0));
		offer_request(compose_request(KIND_LOOKUP, 32'hFFFF_FFFF, '1));
		offer_request(compose_request(KIND_INSERT, 32'h0000_0000, '0));
		offer_request(compose_request(KIND_LOOKUP, 32'h0000_0000, '1));
		offer_request(compose_request(KIND_INSERT, 32'hFFFF_FFFF, '1));
		offer_request(compose_request(KIND_LOOKUP, 32'hFFFF_FFFF, '0));
		// Duplicate insert; the lookup must still return the lowest slot.
		offer_request(compose_request(KIND_INSERT, 32'h0000_0000,
			LEN_W'(MAX_OBJECT_BYTES - 1)));
		offer_request(compose_request(KIND_LOOKUP, 32'h0000_0000, '0));
		offer_request(compose_request(KIND_LOOKUP, 32'h1234_5678, '0));
		// Fill the remaining slots, lengths at and below the object limit.
		for (i = 3; i < N_SLOTS; i++)
			offer_request(compose_request(KIND_INSERT, 32'hA5A5_0000 + i,
				(i % 3 == 0) ? LEN_W'(MAX_OBJECT_BYTES) :
				(i % 3 == 1) ? 17'h0AAAA : 17'h15555));
		offer_request(compose_request(KIND_LOOKUP, 32'hA5A5_0000 + N_SLOTS - 1, '0));
		// Full directory: inserts now evict the least recently used slots.
		offer_request(compose_request(KIND_INSERT, 32'h5A5A_5A5A, 17'h00001));
		offer_request(compose_request(KIND_INSERT, 32'hC3C3_C3C3, 17'h10000));

		foreach (key_pool[k])
			key_pool[k] = $urandom;

		// The first random phase opens with a long receiver hold-off.
		hold_armed <= 1'b1;
		run_phase(0, 0, 230);
		run_phase(69, 0, 230);
		run_phase(0, 69, 230);
		run_phase(21, 21, 235);
		req_valid <= 1'b0;

		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (book.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
